// File: sv/i2a_pkg.sv
// Shared types, constants and helpers for the integer-to-ASCII converter.
// No dependencies.
package i2a_pkg;

    localparam int VALUE_BITS      = 64;   // width of the value_bits field
    localparam int KIND_BITS       = 2;
    localparam int CHAR_BITS       = 7;
    localparam int OUT_TDATA_BITS  = 8;
    localparam int DEF_VALUE_WIDTH = 64;

    localparam logic [CHAR_BITS-1:0] CH_ZERO  = 7'h30;  // '0'
    localparam logic [CHAR_BITS-1:0] CH_MINUS = 7'h2D;  // '-'
    localparam logic [CHAR_BITS-1:0] CH_UPPER = 7'h41;  // 'A'
    localparam logic [CHAR_BITS-1:0] CH_LOWER = 7'h61;  // 'a'

    typedef enum logic [KIND_BITS-1:0] {
        KIND_SDEC = 2'd0,
        KIND_UDEC = 2'd1,
        KIND_HEXL = 2'd2,
        KIND_HEXU = 2'd3
    } t_kind;

    // Formatting flags that travel with one converted value.
    typedef struct packed {
        logic neg;
        logic upper;
    } t_fmt;

    // Digit slots needed for a w-bit value: floor(w*log10(2)) + 1, which
    // also covers the hex nibbles since each BCD digit is four bits.
    function automatic int dec_digits(input int w);
        return ((w * 1233) >> 12) + 1;
    endfunction

    function automatic logic [CHAR_BITS-1:0] nibble_char(input logic [3:0] nib,
                                                         input logic       upper);
        logic [CHAR_BITS-1:0] base;
        if (nib < 4'd10) begin
            return CH_ZERO + {3'b000, nib};
        end
        base = upper ? CH_UPPER : CH_LOWER;
        return base + {3'b000, nib - 4'd10};
    endfunction

endpackage

// File: sv/i2a_dabble.sv
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
// Hex values bypass the shifting and are held as plain nibbles. Uses i2a_pkg.
module i2a_dabble import i2a_pkg::*; #(
    parameter int W    = DEF_VALUE_WIDTH,
    parameter int NDIG = dec_digits(DEF_VALUE_WIDTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic [W-1:0]      i_mag,
    input  logic              i_dec,
    input  t_fmt              i_fmt,
    output logic              o_idle,
    output logic              o_valid,
    input  logic              i_take,
    output logic [NDIG*4-1:0] o_digits,
    output t_fmt              o_fmt
);

    localparam int CW = (W > 1) ? $clog2(W) : 1;

    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_DONE
    } t_dstate;

    t_dstate           r_state;
    logic [W-1:0]      r_bin;
    logic [NDIG*4-1:0] r_bcd;
    logic [CW-1:0]     r_cnt;
    t_fmt              r_fmt;
    logic [NDIG*4-1:0] n_adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            n_adj[i*4 +: 4] = (r_bcd[i*4 +: 4] >= 4'd5) ? r_bcd[i*4 +: 4] + 4'd3
                                                        : r_bcd[i*4 +: 4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            unique case (r_state)
                D_IDLE: begin
                    if (i_load) begin
                        r_fmt <= i_fmt;
                        r_bin <= i_mag;
                        r_cnt <= CW'(W - 1);
                        if (i_dec) begin
                            r_bcd   <= '0;
                            r_state <= D_RUN;
                        end else begin
                            r_bcd   <= (NDIG*4)'(i_mag);
                            r_state <= D_DONE;
                        end
                    end
                end
                D_RUN: begin
                    r_bcd <= {n_adj[NDIG*4-2:0], r_bin[W-1]};
                    r_bin <= r_bin << 1;
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == '0) begin
                        r_state <= D_DONE;
                    end
                end
                D_DONE: begin
                    if (i_take) begin
                        r_state <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_idle   = (r_state == D_IDLE);
    assign o_valid  = (r_state == D_DONE);
    assign o_digits = r_bcd;
    assign o_fmt    = r_fmt;

endmodule

// File: sv/i2a_emit.sv
// Character serializer: drops leading zero digits, adds the sign and sends one
// ASCII word per cycle while the sink accepts, through a registered output stage. Uses i2a_pkg.
module i2a_emit import i2a_pkg::*; #(
    parameter int NDIG = dec_digits(DEF_VALUE_WIDTH)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_take,
    input  logic [NDIG*4-1:0]         i_digits,
    input  t_fmt                      i_fmt,
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [OUT_TDATA_BITS-1:0] o_m_axis_tdata,   // [6:0] ascii_char, [7] zero
    output logic                      o_m_axis_tlast    // last
);

    localparam int LW = $clog2(NDIG + 1);

    typedef enum logic [1:0] {
        E_IDLE,
        E_SKIP,
        E_SIGN,
        E_DIGIT
    } t_estate;

    t_estate              r_state;
    logic [NDIG*4-1:0]    r_dig;
    logic [LW-1:0]        r_left;
    t_fmt                 r_fmt;
    logic                 r_out_valid;
    logic [CHAR_BITS-1:0] r_out_char;
    logic                 r_out_last;
    logic                 n_adv;
    logic [3:0]           n_top;

    assign n_adv = !r_out_valid || i_m_axis_tready;
    assign n_top = r_dig[NDIG*4-1 -: 4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= E_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                E_IDLE: begin
                    if (i_m_axis_tready) begin
                        r_out_valid <= 1'b0;
                    end
                    if (i_valid) begin
                        r_dig   <= i_digits;
                        r_fmt   <= i_fmt;
                        r_left  <= LW'(NDIG);
                        r_state <= E_SKIP;
                    end
                end
                E_SKIP: begin
                    if (i_m_axis_tready) begin
                        r_out_valid <= 1'b0;
                    end
                    // one leading zero per cycle; the last digit always stays
                    if (n_top == 4'd0 && r_left > LW'(1)) begin
                        r_dig  <= r_dig << 4;
                        r_left <= r_left - LW'(1);
                    end else begin
                        r_state <= r_fmt.neg ? E_SIGN : E_DIGIT;
                    end
                end
                E_SIGN: begin
                    if (n_adv) begin
                        r_out_valid <= 1'b1;
                        r_out_char  <= CH_MINUS;
                        r_out_last  <= 1'b0;
                        r_state     <= E_DIGIT;
                    end
                end
                E_DIGIT: begin
                    if (n_adv) begin
                        r_out_valid <= 1'b1;
                        r_out_char  <= nibble_char(n_top, r_fmt.upper);
                        r_out_last  <= (r_left == LW'(1));
                        r_dig       <= r_dig << 4;
                        r_left      <= r_left - LW'(1);
                        if (r_left == LW'(1)) begin
                            r_state <= E_IDLE;
                        end
                    end
                end
            endcase
        end
    end

    assign o_take          = (r_state == E_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_char};
    assign o_m_axis_tlast  = r_out_last;

endmodule

// File: sv/integer_to_ascii_converter.sv
// Integer to ASCII converter: top level over i2a_dabble and i2a_emit; uses i2a_pkg.
// Decimal values run through the BCD shifter, one bit per cycle; hex values skip it.
// The serializer suppresses leading zero digits. A new value is accepted once the
// shifter hands its result on, overlapping the output of the previous value.
// Reset: synchronous, active low; clears both control state machines.
module integer_to_ascii_converter import i2a_pkg::*; #(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [VALUE_BITS-1:0]     i_s_axis_tdata,   // [63:0] value_bits
    input  logic [KIND_BITS-1:0]      i_s_axis_tuser,   // [1:0] kind
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [OUT_TDATA_BITS-1:0] o_m_axis_tdata,   // [6:0] ascii_char, [7] zero
    output logic                      o_m_axis_tlast    // last
);

    localparam int NDIG = dec_digits(VALUE_WIDTH);

    t_kind               w_kind;
    logic [VALUE_WIDTH-1:0] w_val;
    logic [VALUE_WIDTH-1:0] w_mag;
    logic                w_load;
    logic                w_dec;
    t_fmt                w_fmt_in;
    logic                w_dab_idle;
    logic                w_dab_valid;
    logic                w_emit_take;
    logic [NDIG*4-1:0]   w_digits;
    t_fmt                w_fmt;

    assign w_kind         = t_kind'(i_s_axis_tuser);
    assign w_val          = i_s_axis_tdata[VALUE_WIDTH-1:0];
    assign w_fmt_in.neg   = (w_kind == KIND_SDEC) && w_val[VALUE_WIDTH-1];
    assign w_fmt_in.upper = (w_kind == KIND_HEXU);
    assign w_dec          = (w_kind == KIND_SDEC) || (w_kind == KIND_UDEC);
    // modulo 2^W negate, so the most negative value keeps its full magnitude
    assign w_mag = w_fmt_in.neg ? VALUE_WIDTH'(~w_val + VALUE_WIDTH'(1)) : w_val;

    assign o_s_axis_tready = w_dab_idle;
    assign w_load          = i_s_axis_tvalid && w_dab_idle;

    i2a_dabble #(
        .W    (VALUE_WIDTH),
        .NDIG (NDIG)
    ) u_dabble (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_mag    (w_mag),
        .i_dec    (w_dec),
        .i_fmt    (w_fmt_in),
        .o_idle   (w_dab_idle),
        .o_valid  (w_dab_valid),
        .i_take   (w_emit_take),
        .o_digits (w_digits),
        .o_fmt    (w_fmt)
    );

    i2a_emit #(
        .NDIG (NDIG)
    ) u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_dab_valid),
        .o_take          (w_emit_take),
        .i_digits        (w_digits),
        .i_fmt           (w_fmt),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

`ifndef SYNTHESIS
    // a minus sign always has digits after it
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[CHAR_BITS-1:0] == CH_MINUS) |-> !o_m_axis_tlast)
        else $error("minus sign flagged as last word");

    // an accepted value keeps the input from being ready in the cycle after the accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input ready right after accept");

    // the converter only hands over a result while it is not taking input
    a_dab_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dab_valid |-> !w_dab_idle)
        else $error("converter idle and holding a result");
`endif

endmodule

// File: tb/tb_integer_to_ascii_converter.sv
// Self-checking testbench for integer_to_ascii_converter: directed table then random values,
// predicted text compared word by word on the output stream. Uses i2a_pkg and the DUT only.
module tb_integer_to_ascii_converter import i2a_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIDTH       = DEF_VALUE_WIDTH;
    localparam int RAND_VALUES = 308;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 120;    // longer than the worst decimal latency

    typedef struct packed {
        logic [CHAR_BITS-1:0] ch;
        logic                 last;
    } t_char_word;

    // Directed row: an empty text means the predictor supplies the result.
    typedef struct {
        logic [VALUE_BITS-1:0] value;
        t_kind                 kind;
        string                 text;
    } t_dir_row;

    localparam int DIR_ROWS = 22;

    t_dir_row dir_rows[DIR_ROWS] = '{
        '{64'd0,                   KIND_SDEC, "0"},
        '{64'd0,                   KIND_UDEC, "0"},
        '{64'd0,                   KIND_HEXL, "0"},
        '{64'd0,                   KIND_HEXU, "0"},
        '{64'hFFFF_FFFF_FFFF_FFFF, KIND_SDEC, "-1"},
        '{64'hFFFF_FFFF_FFFF_FFFF, KIND_UDEC, "18446744073709551615"},
        '{64'hFFFF_FFFF_FFFF_FFFF, KIND_HEXL, "ffffffffffffffff"},
        '{64'hFFFF_FFFF_FFFF_FFFF, KIND_HEXU, "FFFFFFFFFFFFFFFF"},
        '{64'h8000_0000_0000_0000, KIND_SDEC, "-9223372036854775808"},
        '{64'h8000_0000_0000_0000, KIND_UDEC, "9223372036854775808"},
        '{64'h8000_0000_0000_0000, KIND_HEXL, "8000000000000000"},
        '{64'h7FFF_FFFF_FFFF_FFFF, KIND_SDEC, "9223372036854775807"},
        '{64'd1,                   KIND_SDEC, "1"},
        '{64'd9,                   KIND_UDEC, "9"},
        '{64'd10,                  KIND_UDEC, "10"},
        '{64'hA,                   KIND_HEXL, "a"},
        '{64'hABCDEF,              KIND_HEXU, "ABCDEF"},
        '{64'hABCDEF,              KIND_HEXL, "abcdef"},
        '{64'h0123_4567_89AB_CDEF, KIND_HEXL, "123456789abcdef"},
        '{64'hFFFF_FFFF_FFFF_FFF6, KIND_SDEC, "-10"},
        '{64'd1000000000000000000, KIND_UDEC, ""},
        '{64'h5555_AAAA_0F0F_F0F0, KIND_SDEC, ""}
    };

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_s_axis_tvalid;
    logic                      o_s_axis_tready;
    logic [VALUE_BITS-1:0]     i_s_axis_tdata;   // [63:0] value_bits
    logic [KIND_BITS-1:0]      i_s_axis_tuser;   // [1:0] kind
    logic                      o_m_axis_tvalid;
    logic                      i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] o_m_axis_tdata;   // [6:0] ascii_char, [7] zero
    logic                      o_m_axis_tlast;   // last

    t_char_word expected_chars[$];
    int         mismatch_cnt  = 0;
    int         cycle_cnt     = 0;
    int         src_idle_pct  = 27;
    int         sink_idle_pct = 76;

    integer_to_ascii_converter #(
        .VALUE_WIDTH(WIDTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Text of one value, appended to the expected words.
    function automatic void predict_text(input logic [VALUE_BITS-1:0] raw, input t_kind kind);
        string                 lower_digits = "0123456789abcdef";
        string                 upper_digits = "0123456789ABCDEF";
        logic [VALUE_BITS-1:0] keep_mask;
        logic [VALUE_BITS-1:0] mag;
        logic [CHAR_BITS-1:0]  rev[$];
        logic                  neg;
        byte                   b;
        int                    i;
        keep_mask = (WIDTH >= VALUE_BITS) ? '1 : ((64'd1 << WIDTH) - 64'd1);
        mag = raw & keep_mask;
        neg = 1'b0;
        if (kind == KIND_SDEC && mag[WIDTH-1]) begin
            neg = 1'b1;
            mag = (~mag + 64'd1) & keep_mask;
        end
        if (mag == '0) begin
            rev.push_back(CH_ZERO);
        end else if (kind == KIND_SDEC || kind == KIND_UDEC) begin
            while (mag != '0) begin
                rev.push_back(CH_ZERO + CHAR_BITS'(mag % 64'd10));
                mag = mag / 64'd10;
            end
        end else begin
            while (mag != '0) begin
                if (kind == KIND_HEXU)
                    b = upper_digits[mag[3:0]];
                else
                    b = lower_digits[mag[3:0]];
                rev.push_back(b[CHAR_BITS-1:0]);
                mag = mag >> 4;
            end
        end
        if (neg)
            rev.push_back(CH_MINUS);
        for (i = rev.size() - 1; i >= 0; i--)
            expected_chars.push_back('{ch: rev[i], last: (i == 0)});
    endfunction

    function automatic void queue_text(input string text);
        byte b;
        int  i;
        for (i = 0; i < text.len(); i++) begin
            b = text[i];
            expected_chars.push_back('{ch: b[CHAR_BITS-1:0], last: (i == text.len() - 1)});
        end
    endfunction

    // Mix of magnitudes so every text length and the sign path get exercised.
    function automatic logic [VALUE_BITS-1:0] random_value();
        logic [VALUE_BITS-1:0] r;
        r = {$urandom(), $urandom()};
        case ($urandom_range(0, 4))
            0: random_value = r;
            1: random_value = VALUE_BITS'($urandom_range(0, 999));
            2: random_value = r >> $urandom_range(0, 63);
            3: random_value = -VALUE_BITS'($urandom_range(1, 99999));
            default: begin
                case ($urandom_range(0, 3))
                    0: random_value = 64'h8000_0000_0000_0000;
                    1: random_value = 64'h7FFF_FFFF_FFFF_FFFF;
                    2: random_value = '1;
                    default: random_value = '0;
                endcase
            end
        endcase
    endfunction

    // Offer one word; returns once it has been taken.
    task automatic send_value(input logic [VALUE_BITS-1:0] value, input t_kind kind,
                              input string text);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= value;
        i_s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        if (text.len() != 0)
            queue_text(text);
        else
            predict_text(value, kind);
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_chars.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic note_mismatch(input string what, input t_char_word want);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("mismatch %s: expected '%c' last=%0d, got 0x%02h '%c' last=%0d",
                     what, want.ch, want.last, o_m_axis_tdata,
                     o_m_axis_tdata[CHAR_BITS-1:0], o_m_axis_tlast);
    endtask

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin : out_check
        t_char_word want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_chars.size() == 0) begin
                want = '0;
                note_mismatch("unexpected word", want);
            end else begin
                want = expected_chars.pop_front();
                if (o_m_axis_tdata != {1'b0, want.ch})
                    note_mismatch("char", want);
                else if (o_m_axis_tlast != want.last)
                    note_mismatch("last", want);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int total;
        int n;
        int phase;
        total = DIR_ROWS + RAND_VALUES;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < total; n++) begin
            phase = n * 3 / total;
            if (phase == 1) begin
                src_idle_pct  = 76;
                sink_idle_pct = 27;
            end else if (phase == 2) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            // hold off the source until the converter has fully emptied
            if (n == DIR_ROWS || n == total / 3 || n == 2 * total / 3)
                drain_results();
            if (n < DIR_ROWS)
                send_value(dir_rows[n].value, dir_rows[n].kind, dir_rows[n].text);
            else
                send_value(random_value(), t_kind'($urandom_range(0, 3)), "");
        end

        drain_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_chars.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
